[src/tun_pkg.sv]
// Shared types for the triangle unit normal block.
// Holds the input vertex and output normal transfer structs; no dependencies.
`default_nettype none
package tun_pkg;

	localparam int FIELD_BITS = 16;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] p1_x;
		logic signed [FIELD_BITS-1:0] p1_y;
		logic signed [FIELD_BITS-1:0] p1_z;
		logic signed [FIELD_BITS-1:0] p2_x;
		logic signed [FIELD_BITS-1:0] p2_y;
		logic signed [FIELD_BITS-1:0] p2_z;
		logic signed [FIELD_BITS-1:0] p3_x;
		logic signed [FIELD_BITS-1:0] p3_y;
		logic signed [FIELD_BITS-1:0] p3_z;
	} vert_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] normal_x;
		logic signed [FIELD_BITS-1:0] normal_y;
		logic signed [FIELD_BITS-1:0] normal_z;
		logic                         degenerate;
	} normal_t;

endpackage
`default_nettype wire

[src/tun_sqrt_cell.sv]
// One digit cell of the pipelined integer square root: settles one root bit.
// Carries the three component magnitudes and signs alongside; no package use.
`default_nettype none
module tun_sqrt_cell #(
	parameter int SW = 70,
	parameter int RW = 35,
	parameter int MW = 34
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid_in,
	input  wire logic [SW-1:0]          rad_in,
	input  wire logic [RW+1:0]          rem_in,
	input  wire logic [RW-1:0]          root_in,
	input  wire logic [2:0][MW-1:0]     mag_in,
	input  wire logic [2:0]             neg_in,
	input  wire logic                   deg_in,
	output logic                        valid_out,
	output logic [SW-1:0]               rad_out,
	output logic [RW+1:0]               rem_out,
	output logic [RW-1:0]               root_out,
	output logic [2:0][MW-1:0]          mag_out,
	output logic [2:0]                  neg_out,
	output logic                        deg_out
);

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          ge;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
	assign trial  = {root_in, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_out  <= {rad_in[SW-3:0], 2'b00};
		rem_out  <= ge ? (rem_sh - trial) : rem_sh;
		root_out <= {root_in[RW-2:0], ge};
		mag_out  <= mag_in;
		neg_out  <= neg_in;
		deg_out  <= deg_in;
	end

endmodule
`default_nettype wire

[src/tun_div_cell.sv]
// One step cell of the three-lane restoring divider: one quotient bit per lane.
// All lanes share the divisor (the root); no package use.
`default_nettype none
module tun_div_cell #(
	parameter int RW = 35,
	parameter int QW = 15
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_in,
	input  wire logic [RW-1:0]      div_in,
	input  wire logic [2:0][RW-1:0] rem_in,
	input  wire logic [2:0][QW-1:0] q_in,
	input  wire logic [2:0]         neg_in,
	input  wire logic               deg_in,
	output logic                    valid_out,
	output logic [RW-1:0]           div_out,
	output logic [2:0][RW-1:0]      rem_out,
	output logic [2:0][QW-1:0]      q_out,
	output logic [2:0]              neg_out,
	output logic                    deg_out
);

	logic [2:0][RW:0]   rem2;
	logic [2:0]         ge;
	logic [2:0][RW-1:0] rem_nx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem2[i]   = {rem_in[i], 1'b0};
			ge[i]     = (rem2[i] >= {1'b0, div_in});
			rem_nx[i] = ge[i] ? RW'(rem2[i] - {1'b0, div_in}) : rem2[i][RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		div_out <= div_in;
		rem_out <= rem_nx;
		for (int i = 0; i < 3; i++) begin
			q_out[i] <= {q_in[i][QW-2:0], ge[i]};
		end
		neg_out <= neg_in;
		deg_out <= deg_in;
	end

endmodule
`default_nettype wire

[src/triangle_unit_normal_unit.sv]
// Triangle unit normal: top level with the front-end pipeline and both cell chains.
// Depends on tun_pkg, tun_sqrt_cell and tun_div_cell.
//
// Takes one triangle per clock while busy is low and returns one unit normal per
// triangle, in order. Each triangle passes six front-end stages, then the square
// root chain, one cell per root bit (2*COORD_BITS + 3 cells), then an integer
// quotient stage and the divider chain, one cell per fraction bit, and an output
// register. done is high for one cycle per result and cannot be held off.
// busy is high only while reset is in effect and the cycle after it.
`default_nettype none
module triangle_unit_normal_unit #(
	parameter int COORD_BITS    = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire tun_pkg::vert_t  vert,
	output logic                 busy,
	output logic                 done,
	output tun_pkg::normal_t     result
);
	import tun_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int EW  = CW + 1;
	localparam int PW  = 2 * EW;
	localparam int CXW = PW + 1;
	localparam int MW  = CXW - 1;
	localparam int LO  = MW / 2;
	localparam int HI  = MW - LO;
	localparam int SW  = 2 * MW + 2;
	localparam int RW  = SW / 2;
	localparam int QW  = OUT_FRAC_BITS + 1;
	localparam int XW  = (QW > FIELD_BITS) ? QW : FIELD_BITS + 1;

	function automatic logic signed [CW-1:0] coord(input logic [FIELD_BITS-1:0] f);
		logic [CW-1:0] v;
		for (int i = 0; i < CW; i++) begin
			v[i] = (i < FIELD_BITS) ? f[i % FIELD_BITS] : 1'b0;
		end
		return signed'(v);
	endfunction

	logic run_q;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign busy   = !run_q;
	assign accept = start && run_q;

	// stage 1: edges a = p3 - p2, b = p1 - p2
	logic                        v_s1;
	logic signed [2:0][EW-1:0]   ea_s1, eb_s1;
	logic signed [CW-1:0]        p1 [3];
	logic signed [CW-1:0]        p2 [3];
	logic signed [CW-1:0]        p3 [3];

	always_comb begin
		p1[0] = coord(vert.p1_x); p1[1] = coord(vert.p1_y); p1[2] = coord(vert.p1_z);
		p2[0] = coord(vert.p2_x); p2[1] = coord(vert.p2_y); p2[2] = coord(vert.p2_z);
		p3[0] = coord(vert.p3_x); p3[1] = coord(vert.p3_y); p3[2] = coord(vert.p3_z);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ea_s1[i] <= EW'(p3[i]) - EW'(p2[i]);
			eb_s1[i] <= EW'(p1[i]) - EW'(p2[i]);
		end
	end

	// stage 2: six cross-product terms
	logic                      v_s2;
	logic signed [PW-1:0]      pa_s2 [3];
	logic signed [PW-1:0]      pb_s2 [3];

	always_ff @(posedge clk) begin
		pa_s2[0] <= $signed(ea_s1[1]) * $signed(eb_s1[2]);
		pb_s2[0] <= $signed(ea_s1[2]) * $signed(eb_s1[1]);
		pa_s2[1] <= $signed(ea_s1[2]) * $signed(eb_s1[0]);
		pb_s2[1] <= $signed(ea_s1[0]) * $signed(eb_s1[2]);
		pa_s2[2] <= $signed(ea_s1[0]) * $signed(eb_s1[1]);
		pb_s2[2] <= $signed(ea_s1[1]) * $signed(eb_s1[0]);
	end

	// stage 3: cross components as sign and magnitude
	logic                  v_s3;
	logic [2:0][MW-1:0]    mag_s3;
	logic [2:0]            neg_s3;
	logic signed [CXW-1:0] cx [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cx[i] = CXW'(pa_s2[i]) - CXW'(pb_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s3[i] <= cx[i][CXW-1];
			mag_s3[i] <= cx[i][CXW-1] ? MW'(-cx[i]) : MW'(cx[i]);
		end
	end

	// stage 4: squares split into half-width partial products
	logic                  v_s4;
	logic [2:0][MW-1:0]    mag_s4;
	logic [2:0]            neg_s4;
	logic [2*HI-1:0]       hh_s4 [3];
	logic [HI+LO-1:0]      hl_s4 [3];
	logic [2*LO-1:0]       ll_s4 [3];

	always_ff @(posedge clk) begin
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		for (int i = 0; i < 3; i++) begin
			hh_s4[i] <= mag_s3[i][MW-1:LO] * mag_s3[i][MW-1:LO];
			hl_s4[i] <= mag_s3[i][MW-1:LO] * mag_s3[i][LO-1:0];
			ll_s4[i] <= mag_s3[i][LO-1:0] * mag_s3[i][LO-1:0];
		end
	end

	// stage 5: per-component square
	logic                  v_s5;
	logic [2:0][MW-1:0]    mag_s5;
	logic [2:0]            neg_s5;
	logic [2*MW-1:0]       sq_s5 [3];

	always_ff @(posedge clk) begin
		mag_s5 <= mag_s4;
		neg_s5 <= neg_s4;
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= ((2*MW)'(hh_s4[i]) << (2*LO)) + ((2*MW)'(hl_s4[i]) << (LO+1))
				+ (2*MW)'(ll_s4[i]);
		end
	end

	// stage 6: squared length
	logic                  v_s6;
	logic [2:0][MW-1:0]    mag_s6;
	logic [2:0]            neg_s6;
	logic [SW-1:0]         len2_s6;

	always_ff @(posedge clk) begin
		mag_s6  <= mag_s5;
		neg_s6  <= neg_s5;
		len2_s6 <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// square root chain
	logic                 sq_v    [RW+1];
	logic [SW-1:0]        sq_rad  [RW+1];
	logic [RW+1:0]        sq_rem  [RW+1];
	logic [RW-1:0]        sq_root [RW+1];
	logic [2:0][MW-1:0]   sq_mag  [RW+1];
	logic [2:0]           sq_neg  [RW+1];
	logic                 sq_deg  [RW+1];

	assign sq_v[0]    = v_s6;
	assign sq_rad[0]  = len2_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_mag[0]  = mag_s6;
	assign sq_neg[0]  = neg_s6;
	assign sq_deg[0]  = (len2_s6 == '0);

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		tun_sqrt_cell #(.SW(SW), .RW(RW), .MW(MW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (sq_v[k]),
			.rad_in    (sq_rad[k]),
			.rem_in    (sq_rem[k]),
			.root_in   (sq_root[k]),
			.mag_in    (sq_mag[k]),
			.neg_in    (sq_neg[k]),
			.deg_in    (sq_deg[k]),
			.valid_out (sq_v[k+1]),
			.rad_out   (sq_rad[k+1]),
			.rem_out   (sq_rem[k+1]),
			.root_out  (sq_root[k+1]),
			.mag_out   (sq_mag[k+1]),
			.neg_out   (sq_neg[k+1]),
			.deg_out   (sq_deg[k+1])
		);
	end

	// integer quotient bit: magnitude never exceeds the root
	logic                 v_d0;
	logic [RW-1:0]        div_d0;
	logic [2:0][RW-1:0]   rem_d0;
	logic [2:0][QW-1:0]   q_d0;
	logic [2:0]           neg_d0;
	logic                 deg_d0;
	logic [RW-1:0]        r_root;
	logic [RW-1:0]        a_ext [3];
	logic [2:0]           ge0;

	assign r_root = sq_root[RW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_ext[i] = RW'(sq_mag[RW][i]);
			ge0[i]   = (a_ext[i] >= r_root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d0 <= 1'b0;
		end else begin
			v_d0 <= sq_v[RW];
		end
	end

	always_ff @(posedge clk) begin
		div_d0 <= r_root;
		for (int i = 0; i < 3; i++) begin
			rem_d0[i] <= ge0[i] ? (a_ext[i] - r_root) : a_ext[i];
			q_d0[i]   <= QW'(ge0[i]);
		end
		neg_d0 <= sq_neg[RW];
		deg_d0 <= sq_deg[RW];
	end

	// fraction bits chain
	logic                 dv_v   [OUT_FRAC_BITS+1];
	logic [RW-1:0]        dv_div [OUT_FRAC_BITS+1];
	logic [2:0][RW-1:0]   dv_rem [OUT_FRAC_BITS+1];
	logic [2:0][QW-1:0]   dv_q   [OUT_FRAC_BITS+1];
	logic [2:0]           dv_neg [OUT_FRAC_BITS+1];
	logic                 dv_deg [OUT_FRAC_BITS+1];

	assign dv_v[0]   = v_d0;
	assign dv_div[0] = div_d0;
	assign dv_rem[0] = rem_d0;
	assign dv_q[0]   = q_d0;
	assign dv_neg[0] = neg_d0;
	assign dv_deg[0] = deg_d0;

	for (genvar k = 0; k < OUT_FRAC_BITS; k++) begin : g_div
		tun_div_cell #(.RW(RW), .QW(QW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (dv_v[k]),
			.div_in    (dv_div[k]),
			.rem_in    (dv_rem[k]),
			.q_in      (dv_q[k]),
			.neg_in    (dv_neg[k]),
			.deg_in    (dv_deg[k]),
			.valid_out (dv_v[k+1]),
			.div_out   (dv_div[k+1]),
			.rem_out   (dv_rem[k+1]),
			.q_out     (dv_q[k+1]),
			.neg_out   (dv_neg[k+1]),
			.deg_out   (dv_deg[k+1])
		);
	end

	// output: apply sign, saturate, zero on a degenerate triangle
	logic [XW-1:0]         qx  [3];
	logic [FIELD_BITS-1:0] res [3];
	logic                  done_q;
	normal_t               result_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qx[i] = XW'(dv_q[OUT_FRAC_BITS][i]);
			if (dv_deg[OUT_FRAC_BITS]) begin
				res[i] = '0;
			end else if (dv_neg[OUT_FRAC_BITS][i]) begin
				res[i] = (qx[i] > XW'(32768)) ? 16'h8000 : FIELD_BITS'(-qx[i]);
			end else begin
				res[i] = (qx[i] > XW'(32767)) ? 16'h7FFF : qx[i][FIELD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v[OUT_FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		result_q.normal_x   <= res[0];
		result_q.normal_y   <= res[1];
		result_q.normal_z   <= res[2];
		result_q.degenerate <= dv_deg[OUT_FRAC_BITS];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[src/tun_checker.sv]
// Port-level checker for the triangle unit normal block, bound to the top level.
// Depends on tun_pkg for the result struct.
`default_nettype none
module tun_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire tun_pkg::normal_t result
);
	import tun_pkg::*;

	// a degenerate result carries an all-zero normal
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |->
			result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
		else $error("degenerate result with nonzero normal");

	// a proper normal always has some nonzero component
	a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.degenerate |->
			result.normal_x != '0 || result.normal_y != '0 || result.normal_z != '0)
		else $error("nondegenerate result with zero normal");

	// once out of reset the block keeps taking transfers
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

	// no result shows while the block is still coming out of reset
	a_no_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while busy");

endmodule

bind triangle_unit_normal_unit tun_checker u_tun_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

[sim/tb.sv]
// Testbench for triangle_unit_normal_unit: random and directed triangles with a
// self-checking unit normal predictor. Depends on tun_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import tun_pkg::*;

	localparam int N_RANDOM  = 1530;
	localparam int HOLD_AT   = 700;
	localparam int LATENCY   = 57;
	localparam int MAX_CYCLE = 400000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	vert_t   vert = '0;
	logic    busy;
	logic    done;
	normal_t result;

	vert_t   tri_q[$];
	normal_t normal_q[$];
	int      sent = 0;
	int      errors = 0;
	int      cycles = 0;
	int      burst_left = 4;
	int      gap_left = 0;

	triangle_unit_normal_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .vert(vert),
		.busy(busy), .done(done), .result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// trunc(|c| * 2^14 / len), signed and saturated to 16 bits
	function automatic logic [15:0] scale_comp(longint c, logic [63:0] len);
		logic [63:0] a, q;
		a = (c < 0) ? 64'(-c) : 64'(c);
		q = (a << 14) / len;
		if (c < 0) begin
			if (q > 64'd32768) q = 64'd32768;
			return 16'(-q);
		end
		if (q > 64'd32767) q = 64'd32767;
		return q[15:0];
	endfunction

	function automatic normal_t unit_normal(vert_t v);
		longint ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [127:0] sq, c2;
		logic [63:0] len, cand;
		normal_t n;
		ax = longint'(v.p3_x) - longint'(v.p2_x);
		ay = longint'(v.p3_y) - longint'(v.p2_y);
		az = longint'(v.p3_z) - longint'(v.p2_z);
		bx = longint'(v.p1_x) - longint'(v.p2_x);
		by = longint'(v.p1_y) - longint'(v.p2_y);
		bz = longint'(v.p1_z) - longint'(v.p2_z);
		cx = ay * bz - az * by;
		cy = az * bx - ax * bz;
		cz = ax * by - ay * bx;
		// square at full width: a cross component reaches about 2^33
		sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
		n = '0;
		if (sq == 0) begin
			n.degenerate = 1'b1;
			return n;
		end
		len = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = len | (64'd1 << b);
			c2 = {64'd0, cand} * {64'd0, cand};
			if (c2 <= sq) len = cand;
		end
		n.normal_x = scale_comp(cx, len);
		n.normal_y = scale_comp(cy, len);
		n.normal_z = scale_comp(cz, len);
		return n;
	endfunction

	function automatic vert_t mk(int x1, int y1, int z1, int x2, int y2, int z2,
			int x3, int y3, int z3);
		vert_t v;
		v.p1_x = 16'(x1); v.p1_y = 16'(y1); v.p1_z = 16'(z1);
		v.p2_x = 16'(x2); v.p2_y = 16'(y2); v.p2_z = 16'(z2);
		v.p3_x = 16'(x3); v.p3_y = 16'(y3); v.p3_z = 16'(z3);
		return v;
	endfunction

	function automatic int rnd_coord(int kind);
		case (kind)
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 64) - 32;
			2: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $urandom_range(0, 1024) - 512;
		endcase
	endfunction

	// driver: one triangle per transfer, bursts and gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				normal_q.push_back(unit_normal(vert));
				sent++;
			end
			if (start && busy) begin
				// hold until the block takes it
			end else if (tri_q.size() > 0 && gap_left == 0 &&
					!(sent == HOLD_AT && normal_q.size() != 0)) begin
				vert <= tri_q.pop_front();
				start <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
	end

	// monitor: every strobe is one result transfer
	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) begin
			if (normal_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				normal_t e;
				e = normal_q.pop_front();
				if (result.normal_x !== e.normal_x)
					$display("%0t: normal_x exp %0d got %0d", $time, e.normal_x,
						result.normal_x);
				if (result.normal_y !== e.normal_y)
					$display("%0t: normal_y exp %0d got %0d", $time, e.normal_y,
						result.normal_y);
				if (result.normal_z !== e.normal_z)
					$display("%0t: normal_z exp %0d got %0d", $time, e.normal_z,
						result.normal_z);
				if (result.degenerate !== e.degenerate)
					$display("%0t: degenerate exp %0b got %0b", $time, e.degenerate,
						result.degenerate);
				if (result !== e) errors++;
			end
		end
		if (cycles > MAX_CYCLE) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int k, x, y, z, m;
		// directed: degenerate, axis normals, extremes
		tri_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		tri_q.push_back(mk(5, 5, 5, 5, 5, 5, 9, 1, 2));
		tri_q.push_back(mk(1, 2, 3, 2, 4, 6, 3, 6, 9));
		tri_q.push_back(mk(256, 0, 0, 0, 0, 0, 0, 256, 0));
		tri_q.push_back(mk(0, 256, 0, 0, 0, 0, 256, 0, 0));
		tri_q.push_back(mk(0, 0, 256, 0, 0, 0, 256, 0, 0));
		tri_q.push_back(mk(256, 0, 0, 0, 0, 0, 0, 0, 256));
		tri_q.push_back(mk(0, 0, 256, 0, 0, 0, 0, 256, 0));
		tri_q.push_back(mk(0, 256, 0, 0, 0, 0, 0, 0, 256));
		tri_q.push_back(mk(32767, -32768, -32768, -32768, -32768, -32768,
			-32768, 32767, -32768));
		tri_q.push_back(mk(-32768, 32767, 32767, 32767, 32767, 32767,
			32767, -32768, 32767));
		tri_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, 32767));
		tri_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768,
			-32768, 32767, -32768));
		tri_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
		tri_q.push_back(mk(-1, -1, -1, 32767, 32767, 32767, 0, 0, 0));
		tri_q.push_back(mk(32767, 0, 0, -32768, 0, 0, 0, 32767, 32767));
		tri_q.push_back(mk(3, 4, 0, 0, 0, 0, 0, 0, 5));
		tri_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
			32767, 32767, 32767));
		for (int i = 0; i < N_RANDOM; i++) begin
			k = $urandom_range(0, 9);
			if (k == 0) begin
				// collinear: p1 and p3 on one line through p2
				x = rnd_coord(1); y = rnd_coord(1); z = rnd_coord(1);
				m = $urandom_range(0, 6) - 3;
				tri_q.push_back(mk(100 + x, 200 + y, -50 + z, 100, 200, -50,
					100 + m * x, 200 + m * y, -50 + m * z));
			end else begin
				m = (k < 6) ? 0 : k - 5;
				tri_q.push_back(mk(rnd_coord(m), rnd_coord(m), rnd_coord(m),
					rnd_coord(m), rnd_coord(m), rnd_coord(m),
					rnd_coord(m), rnd_coord(m), rnd_coord(m)));
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (tri_q.size() == 0 && !start && normal_q.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && normal_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
